### design/bid_pkg.sv
`timescale 1ns / 1ps

package bid_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_CALC
	} bid_state_t;

	typedef struct packed {
		logic [7:0] tl;
		logic [7:0] tr;
		logic [7:0] bl;
		logic [7:0] br;
	} bid_quad_t;

	typedef struct packed {
		logic [5:0] col;
		logic [5:0] row;
		logic       last;
	} bid_tag_t;

endpackage

### design/bid_line_store.sv
`timescale 1ns / 1ps

module bid_line_store #(
	parameter int DEPTH = 320,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/bid_axis.sv
`timescale 1ns / 1ps

module bid_axis #(
	parameter int LEN      = 320,
	parameter int OUT_SIZE = 50,
	parameter int PW       = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              restart,
	input  logic                              step,
	input  logic                              reload,
	input  logic [PW-1:0]                     pos,
	output logic [$clog2(OUT_SIZE+1)-1:0]     idx,
	output logic [$clog2(2*OUT_SIZE)-1:0]     frac,
	output logic                              hit
);

	localparam int W    = 2 * OUT_SIZE;
	localparam int FW   = $clog2(W);
	localparam int IW   = $clog2(OUT_SIZE + 1);
	localparam int TW   = $clog2(2 * LEN) + 1;
	localparam int NUM0 = LEN - OUT_SIZE;
	localparam int B0   = NUM0 / W;
	localparam int F0   = NUM0 % W;
	localparam int BI   = (2 * LEN) / W;
	localparam int FI   = (2 * LEN) % W;

	logic [IW-1:0] idx_q;
	logic [TW-1:0] base_q;
	logic [FW-1:0] frac_q;
	logic [TW-1:0] base;
	logic [TW-1:0] trig;
	logic [FW:0]   fsum;
	logic          wrap;
	logic [FW-1:0] nfrac;
	logic [TW-1:0] nbase;

	always_comb begin
		idx   = restart ? '0 : idx_q;
		base  = restart ? TW'(B0) : base_q;
		frac  = restart ? FW'(F0) : frac_q;
		trig  = base + TW'(frac != '0);
		hit   = (idx < IW'(OUT_SIZE)) && (trig == TW'(pos));
		fsum  = {1'b0, frac} + (FW+1)'(FI);
		wrap  = fsum >= (FW+1)'(W);
		nfrac = wrap ? FW'(fsum - (FW+1)'(W)) : fsum[FW-1:0];
		nbase = base + TW'(BI) + TW'(wrap);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			base_q <= TW'(B0);
			frac_q <= FW'(F0);
		end else if (en) begin
			if (reload) begin
				idx_q  <= '0;
				base_q <= TW'(B0);
				frac_q <= FW'(F0);
			end else if (step) begin
				idx_q  <= idx + IW'(1);
				base_q <= nbase;
				frac_q <= nfrac;
			end else begin
				idx_q  <= idx;
				base_q <= base;
				frac_q <= frac;
			end
		end
	end

endmodule

### design/bid_interp.sv
`timescale 1ns / 1ps

module bid_interp #(
	parameter int OUT_SIZE = 50
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  bid_pkg::bid_quad_t                quad,
	input  logic [$clog2(2*OUT_SIZE)-1:0]     fx,
	input  logic [$clog2(2*OUT_SIZE)-1:0]     fy,
	input  bid_pkg::bid_tag_t                 tag,
	output logic                              done,
	output logic [7:0]                        value,
	output bid_pkg::bid_tag_t                 tag_out
);

	import bid_pkg::*;

	localparam int W    = 2 * OUT_SIZE;
	localparam int FW   = $clog2(W);
	localparam int D    = W * W;
	localparam int TOPW = $clog2(W * 255 + 1);
	localparam int NW   = $clog2(D * 255 + 1);
	localparam int S    = NW;
	localparam int M    = (2 ** S) / D;
	localparam int MW   = $clog2(M + 1);
	localparam int PW   = NW + MW;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	bid_tag_t        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic [TOPW-1:0] top_s1, bot_s1;
	logic [FW-1:0]   fy_s1;
	logic [NW-1:0]   n_s2, n_s3, n_s4, n_s5;
	logic [PW-1:0]   p_s3;
	logic [7:0]      q_s4, q_s5;
	logic [NW-1:0]   qd_s5;
	logic [7:0]      val_s6;
	logic [FW:0]     wfx;
	logic [FW:0]     wfy;
	logic [NW-1:0]   rem;

	always_comb begin
		wfx = (FW+1)'(W) - {1'b0, fx};
		wfy = (FW+1)'(W) - {1'b0, fy_s1};
		rem = n_s5 - qd_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		top_s1 <= TOPW'(wfx) * TOPW'(quad.tl) + TOPW'(fx) * TOPW'(quad.tr);
		bot_s1 <= TOPW'(wfx) * TOPW'(quad.bl) + TOPW'(fx) * TOPW'(quad.br);
		fy_s1  <= fy;
		tag_s1 <= tag;

		n_s2   <= NW'(wfy) * NW'(top_s1) + NW'(fy_s1) * NW'(bot_s1);
		tag_s2 <= tag_s1;

		p_s3   <= PW'(n_s2) * PW'(M);
		n_s3   <= n_s2;
		tag_s3 <= tag_s2;

		q_s4   <= p_s3[S +: 8];
		n_s4   <= n_s3;
		tag_s4 <= tag_s3;

		qd_s5  <= NW'(q_s4) * NW'(D);
		q_s5   <= q_s4;
		n_s5   <= n_s4;
		tag_s5 <= tag_s4;

		val_s6 <= (rem >= NW'(D)) ? q_s5 + 8'd1 : q_s5;
		tag_s6 <= tag_s5;
	end

	assign done    = v_s6;
	assign value   = val_s6;
	assign tag_out = tag_s6;

endmodule

### design/bilinear_image_downscaler_top.sv
// Flow: a pixel that completes an output is registered with its weights, its quad is then
//   registered from the line store read, the FSM waits for a free output slot, and the
//   6-stage multiply/divide unit then feeds the registered out_valid beat. A new pixel is
//   taken only in idle, after the previous pixel and any output it completes are through.
// Reset: arst_n clears counters and control; then the line store is swept to zero,
//   one entry per cycle over all IN_WIDTH entries, before the first pixel is taken.
`timescale 1ns / 1ps

module bilinear_image_downscaler_top #(
	parameter int IN_WIDTH  = 320,
	parameter int IN_HEIGHT = 240,
	parameter int OUT_SIZE  = 50
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [7:0] pixel,
	input  logic       frame_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_pixel,
	output logic [5:0] out_col,
	output logic [5:0] out_row,
	output logic       last
);

	import bid_pkg::*;

	localparam int CW = $clog2(IN_WIDTH);
	localparam int RW = $clog2(IN_HEIGHT);
	localparam int FW = $clog2(2 * OUT_SIZE);
	localparam int IW = $clog2(OUT_SIZE + 1);

	bid_state_t    state_q, state_d;
	logic [CW-1:0] clr_q;
	logic [CW-1:0] src_col_q;
	logic [RW-1:0] src_row_q;
	logic [7:0]    left_cur_q, left_prev_q;

	logic          accept;
	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic          eol, eof;
	logic          col_hit, row_hit;
	logic [IW-1:0] col_idx, row_idx;
	logic [FW-1:0] fx, fy;

	logic          mem_we;
	logic [CW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [7:0]    up;

	logic [7:0]    pix_s1;
	logic [FW-1:0] fx_s1, fy_s1;
	logic          emit_s1;
	bid_tag_t      tag_s1;
	bid_quad_t     quad_d, quad_q;

	logic          slot_free;
	logic          start;
	logic          done;
	logic [7:0]    value;
	bid_tag_t      tag_out;

	logic          out_valid_q;
	logic [7:0]    out_pixel_q;
	bid_tag_t      out_tag_q;

	assign accept = valid && ready;
	assign c      = frame_start ? '0 : src_col_q;
	assign r      = frame_start ? '0 : src_row_q;
	assign eol    = c == CW'(IN_WIDTH - 1);
	assign eof    = r == RW'(IN_HEIGHT - 1);

	bid_axis #(.LEN(IN_WIDTH), .OUT_SIZE(OUT_SIZE), .PW(CW)) u_col (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.restart (frame_start),
		.step    (col_hit),
		.reload  (eol),
		.pos     (c),
		.idx     (col_idx),
		.frac    (fx),
		.hit     (col_hit)
	);

	bid_axis #(.LEN(IN_HEIGHT), .OUT_SIZE(OUT_SIZE), .PW(RW)) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.restart (frame_start),
		.step    (eol && row_hit),
		.reload  (eol && eof),
		.pos     (r),
		.idx     (row_idx),
		.frac    (fy),
		.hit     (row_hit)
	);

	always_comb begin
		mem_we    = (state_q == ST_CLEAR) || accept;
		mem_waddr = (state_q == ST_CLEAR) ? clr_q : c;
		mem_wdata = (state_q == ST_CLEAR) ? 8'd0 : pixel;
	end

	bid_line_store #(.DEPTH(IN_WIDTH), .AW(CW)) u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (c),
		.rdata (up)
	);

	always_comb begin
		quad_d.br = pix_s1;
		quad_d.bl = (fx_s1 != '0) ? left_cur_q : pix_s1;
		quad_d.tl = (fx_s1 != '0) ? left_prev_q : up;
		quad_d.tr = up;
		if (fy_s1 == '0) begin
			quad_d.tl = quad_d.bl;
			quad_d.tr = quad_d.br;
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		ready   = 1'b0;
		start   = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == CW'(IN_WIDTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready = 1'b1;
				if (valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = emit_s1 ? ST_WAIT : ST_IDLE;
			end
			ST_WAIT: begin
				if (slot_free) begin
					start   = 1'b1;
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				if (done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			src_col_q   <= '0;
			src_row_q   <= '0;
			left_cur_q  <= '0;
			left_prev_q <= '0;
			emit_s1     <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (accept) begin
				emit_s1 <= col_hit && row_hit;
				if (eol) begin
					src_col_q <= '0;
					src_row_q <= eof ? '0 : r + RW'(1);
				end else begin
					src_col_q <= c + CW'(1);
					src_row_q <= r;
				end
			end
			if (state_q == ST_READ) begin
				left_prev_q <= up;
				left_cur_q  <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel;
			fx_s1       <= fx;
			fy_s1       <= fy;
			tag_s1.col  <= 6'(col_idx);
			tag_s1.row  <= 6'(row_idx);
			tag_s1.last <= (col_idx == IW'(OUT_SIZE - 1)) && (row_idx == IW'(OUT_SIZE - 1));
		end
		if (state_q == ST_READ) begin
			quad_q <= quad_d;
		end
	end

	bid_interp #(.OUT_SIZE(OUT_SIZE)) u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.quad    (quad_q),
		.fx      (fx_s1),
		.fy      (fy_s1),
		.tag     (tag_s1),
		.done    (done),
		.value   (value),
		.tag_out (tag_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_pixel_q <= value;
			out_tag_q   <= tag_out;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_col   = out_tag_q.col;
	assign out_row   = out_tag_q.row;
	assign last      = out_tag_q.last;

endmodule

### design/bid_checker.sv
`timescale 1ns / 1ps

module bid_checker #(
	parameter int OUT_SIZE = 50
) (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_pixel,
	input logic [5:0] out_col,
	input logic [5:0] out_row,
	input logic       last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_col) &&
			$stable(out_row) && $stable(last))
		else $error("output beat changed while stalled");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_col == 6'(OUT_SIZE - 1) && out_row == 6'(OUT_SIZE - 1))
		else $error("last flag on wrong output position");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (int'(out_col) < OUT_SIZE) && (int'(out_row) < OUT_SIZE))
		else $error("output index out of range");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && ready |=> !ready)
		else $error("input taken in back-to-back cycles");

	a_new_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!$past(out_valid) || $past(out_ready)) |-> !$past(ready))
		else $error("new output beat while input side was idle");

endmodule

bind bilinear_image_downscaler_top bid_checker #(.OUT_SIZE(OUT_SIZE)) u_bid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.valid     (valid),
	.ready     (ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_pixel (out_pixel),
	.out_col   (out_col),
	.out_row   (out_row),
	.last      (last)
);
